/* sv/segment_rotate_project_macros.svh */
// Assertion helpers for the segment projection block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SEGMENT_ROTATE_PROJECT_MACROS_SVH
`define SEGMENT_ROTATE_PROJECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/srp_pkg.sv */
`default_nettype none

package srp_pkg;

  // Field widths
  localparam int COORD_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ROT_W          = 12;
  localparam int INCL_W         = 17;
  localparam int INCL_FRAC      = 16;
  localparam int OFS_W          = 12;
  localparam int OUT_W          = 19;
  localparam int TAG_W          = 16;
  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 2;

  // Datapath widths
  localparam int SIN_W      = TRIG_FRAC_BITS + 1;   // magnitude of sin/cos, 0..1.0
  localparam int SC_W       = TRIG_FRAC_BITS + 2;   // signed sin/cos
  localparam int PROD_W     = COORD_BITS + SC_W;
  localparam int D_W        = PROD_W + 2;           // sum of four products
  localparam int OMI_W      = INCL_W + 1;           // signed (1 - incl)
  localparam int PRJ_W      = D_W + OMI_W;
  localparam int ZO_W       = COORD_BITS + 2;       // y_offset - z
  localparam int FRAC_SHIFT = TRIG_FRAC_BITS + INCL_FRAC;
  localparam int V_W        = PRJ_W + 1;
  localparam int Q_W        = V_W - FRAC_SHIFT;

  localparam int INCL_ONE   = 2 ** INCL_FRAC;
  localparam int INCL_RESET = INCL_ONE / 2;
  localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN    = -(2 ** (OUT_W - 1));

  // Angle handling, tenths of a degree
  localparam int FULL_TENTHS    = 3600;
  localparam int QUARTER_TENTHS = 900;
  localparam int HALF_TENTHS    = 2 * QUARTER_TENTHS;
  localparam int THREEQ_TENTHS  = 3 * QUARTER_TENTHS;
  localparam int TAB_DEPTH      = QUARTER_TENTHS + 1;
  localparam int ANG_W          = $clog2(TAB_DEPTH);

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SERIES_TERMS = 11;

  // Pipeline depth of the point datapath
  localparam int NSTG = 6;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION    = CFG_IDX_W'(0),
    CFG_INCLINATION = CFG_IDX_W'(1),
    CFG_X_OFFSET    = CFG_IDX_W'(2),
    CFG_Y_OFFSET    = CFG_IDX_W'(3)
  } cfg_idx_t;

  // Per-stage load enables for the point pipelines
  typedef struct packed {
    logic st0;
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
  } srp_adv_t;

  typedef logic [SIN_W-1:0] sin_tab_t [0:TAB_DEPTH-1];

  // Series step k: floor division by (2k)(2k+1)
  function automatic longint unsigned series_div(input longint unsigned n, input int k);
    case (k)
      1:       return n / 64'd6;
      2:       return n / 64'd20;
      3:       return n / 64'd42;
      4:       return n / 64'd72;
      5:       return n / 64'd110;
      6:       return n / 64'd156;
      7:       return n / 64'd210;
      8:       return n / 64'd272;
      9:       return n / 64'd342;
      10:      return n / 64'd420;
      default: return n / 64'd506;
    endcase
  endfunction

  // Quarter-wave sine table, Taylor series in Q30, rounded to TRIG_FRAC_BITS.
  // Evaluated at elaboration only.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int              t;
    int              k;
    for (t = 0; t < TAB_DEPTH; t++) begin
      x    = (longint'(t) * PI_Q30 + longint'(HALF_TENTHS / 2)) / HALF_TENTHS;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= SERIES_TERMS; k++) begin
        term = series_div((term * x2) >> 30, k);
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[t] = SIN_W'((sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

/* sv/srp_trig.sv */
`default_nettype none

// Sine/cosine of the configured angle, three register stages, free running
module srp_trig import srp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [ROT_W-1:0]        rotation,
  output logic signed [SC_W-1:0]       sin_val,
  output logic signed [SC_W-1:0]       cos_val
);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  logic [ROT_W-1:0]        ang_wrap;
  quad_t                   quad_nxt;
  logic [ANG_W-1:0]        ang_nxt;
  quad_t                   quad_r;
  logic [ANG_W-1:0]        ang_r;
  logic [ANG_W-1:0]        comp_r;
  quad_t                   quad2_r;
  logic [SIN_W-1:0]        sa_r;
  logic [SIN_W-1:0]        sb_r;
  logic signed [SC_W-1:0]  a_s;
  logic signed [SC_W-1:0]  b_s;
  logic signed [SC_W-1:0]  sin_nxt;
  logic signed [SC_W-1:0]  cos_nxt;
  logic signed [SC_W-1:0]  sin_r;
  logic signed [SC_W-1:0]  cos_r;

  // Stage 1: wrap to one turn, split into quadrant and offset in the quadrant
  always_comb begin
    ang_wrap = (rotation >= ROT_W'(FULL_TENTHS)) ? rotation - ROT_W'(FULL_TENTHS) : rotation;
    if (ang_wrap >= ROT_W'(THREEQ_TENTHS)) begin
      quad_nxt = QUAD_3;
      ang_nxt  = ANG_W'(ang_wrap - ROT_W'(THREEQ_TENTHS));
    end else if (ang_wrap >= ROT_W'(HALF_TENTHS)) begin
      quad_nxt = QUAD_2;
      ang_nxt  = ANG_W'(ang_wrap - ROT_W'(HALF_TENTHS));
    end else if (ang_wrap >= ROT_W'(QUARTER_TENTHS)) begin
      quad_nxt = QUAD_1;
      ang_nxt  = ANG_W'(ang_wrap - ROT_W'(QUARTER_TENTHS));
    end else begin
      quad_nxt = QUAD_0;
      ang_nxt  = ANG_W'(ang_wrap);
    end
  end

  always_ff @(posedge clk) begin
    quad_r <= quad_nxt;
    ang_r  <= ang_nxt;
    comp_r <= ANG_W'(QUARTER_TENTHS) - ang_nxt;
  end

  // Stage 2: table lookup, sine of the offset and of its complement
  always_ff @(posedge clk) begin
    sa_r    <= SIN_TAB[ang_r];
    sb_r    <= SIN_TAB[comp_r];
    quad2_r <= quad_r;
  end

  // Stage 3: quadrant swap and signs
  always_comb begin
    a_s = signed'(SC_W'(sa_r));
    b_s = signed'(SC_W'(sb_r));
    unique case (quad2_r)
      QUAD_0: begin sin_nxt = a_s;  cos_nxt = b_s;  end
      QUAD_1: begin sin_nxt = b_s;  cos_nxt = -a_s; end
      QUAD_2: begin sin_nxt = -a_s; cos_nxt = -b_s; end
      QUAD_3: begin sin_nxt = -b_s; cos_nxt = a_s;  end
      default: begin sin_nxt = a_s; cos_nxt = b_s;  end
    endcase
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

`default_nettype wire

/* sv/srp_point.sv */
`default_nettype none

// Rotate and project one endpoint; six register stages driven by adv
module srp_point import srp_pkg::*; (
  input  wire logic                          clk,
  input  wire srp_adv_t                      adv,
  input  wire logic signed [SC_W-1:0]        sin_val,
  input  wire logic signed [SC_W-1:0]        cos_val,
  input  wire logic [INCL_W-1:0]             incl,
  input  wire logic [OFS_W-1:0]              x_off,
  input  wire logic [OFS_W-1:0]              y_off,
  input  wire logic signed [COORD_BITS-1:0]  in_x,
  input  wire logic signed [COORD_BITS-1:0]  in_y,
  input  wire logic signed [COORD_BITS-1:0]  in_z,
  output logic signed [OUT_W-1:0]            out_sx,
  output logic signed [OUT_W-1:0]            out_sy
);

  // Divide by 2^FRAC_SHIFT rounding toward zero, then clamp to the output range
  function automatic logic signed [OUT_W-1:0] trunc_sat(input logic signed [V_W-1:0] v);
    logic signed [Q_W-1:0] q;
    logic signed [Q_W-1:0] qt;
    q  = v[V_W-1:FRAC_SHIFT];
    qt = (v[V_W-1] && (|v[FRAC_SHIFT-1:0])) ? q + Q_W'(1) : q;
    if (qt > Q_W'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end else if (qt < Q_W'(OUT_MIN)) begin
      return OUT_W'(OUT_MIN);
    end else begin
      return OUT_W'(qt);
    end
  endfunction

  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic signed [PROD_W-1:0]     xc_r, ys_r, xs_r, yc_r;
  logic signed [COORD_BITS-1:0] z1_r, z2_r;
  logic signed [D_W-1:0]        d_nxt, u_nxt, d_r, u_r;
  logic signed [OMI_W-1:0]      incl_s, omi_s;
  logic signed [PRJ_W-1:0]      prx_nxt, pry_nxt, prx_r, pry_r;
  logic signed [ZO_W-1:0]       yz_nxt, yz_r;
  logic [OFS_W-1:0]             xo_r;
  logic signed [V_W-1:0]        vx_nxt, vy_nxt, vx_r, vy_r;
  logic signed [OUT_W-1:0]      sx_r, sy_r;

  // Rotation sums: d = rx - ry, u = rx + ry
  always_comb begin
    d_nxt = D_W'(xc_r) - D_W'(ys_r) - D_W'(xs_r) - D_W'(yc_r);
    u_nxt = D_W'(xc_r) - D_W'(ys_r) + D_W'(xs_r) + D_W'(yc_r);
  end

  // Projection products and the height term
  always_comb begin
    incl_s  = signed'({1'b0, incl});
    omi_s   = signed'(OMI_W'(INCL_ONE)) - incl_s;
    prx_nxt = PRJ_W'(d_r) * PRJ_W'(incl_s);
    pry_nxt = PRJ_W'(u_r) * PRJ_W'(omi_s);
    yz_nxt  = ZO_W'(signed'({1'b0, y_off})) - ZO_W'(z2_r);
  end

  // Offsets at full fractional scale
  always_comb begin
    vx_nxt = V_W'(prx_r) + (V_W'(signed'({1'b0, xo_r})) <<< FRAC_SHIFT);
    vy_nxt = V_W'(pry_r) + (V_W'(yz_r) <<< FRAC_SHIFT);
  end

  always_ff @(posedge clk) begin
    // stage 0: capture the request
    if (adv.st0) begin
      x_r <= in_x;
      y_r <= in_y;
      z_r <= in_z;
    end
    // stage 1: rotation products
    if (adv.st1) begin
      xc_r <= x_r * cos_val;
      ys_r <= y_r * sin_val;
      xs_r <= x_r * sin_val;
      yc_r <= y_r * cos_val;
      z1_r <= z_r;
    end
    // stage 2
    if (adv.st2) begin
      d_r  <= d_nxt;
      u_r  <= u_nxt;
      z2_r <= z1_r;
    end
    // stage 3
    if (adv.st3) begin
      prx_r <= prx_nxt;
      pry_r <= pry_nxt;
      yz_r  <= yz_nxt;
      xo_r  <= x_off;
    end
    // stage 4
    if (adv.st4) begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
    // stage 5: output register
    if (adv.st5) begin
      sx_r <= trunc_sat(vx_r);
      sy_r <= trunc_sat(vy_r);
    end
  end

  assign out_sx = sx_r;
  assign out_sy = sy_r;

endmodule

`default_nettype wire

/* sv/segment_rotate_project.sv */
// Segment rotate and isometric projection.
// Input channel (in_valid / in_stall): one segment request per accepted
// cycle, two 3-D endpoints and a tag. Output channel (out_valid /
// out_stall): the two screen points and the unchanged tag, one result per
// request, in request order.
// Configuration: cfg_we with cfg_index / cfg_wdata writes angle,
// inclination and the two screen offsets. Write only while no request is
// in flight; a write stalls the input for that cycle and while the
// sine/cosine lookup settles.
// Each request passes through the six-stage point pipelines (one per
// endpoint), each stage with its own valid bit. Throughput: one request
// per cycle unless out_stall, a configuration write or the trig settle
// holds the input.
// Reset (rst_n low, synchronous) empties the pipeline, loads the register
// defaults and holds in_stall high while the trig lookup settles. When the
// receiver stalls, the result holds and stages behind it keep filling
// bubbles before in_stall rises.
`default_nettype none
`include "segment_rotate_project_macros.svh"

module segment_rotate_project import srp_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  in_first_x,
  input  wire logic signed [COORD_BITS-1:0]  in_first_y,
  input  wire logic signed [COORD_BITS-1:0]  in_first_z,
  input  wire logic signed [COORD_BITS-1:0]  in_second_x,
  input  wire logic signed [COORD_BITS-1:0]  in_second_y,
  input  wire logic signed [COORD_BITS-1:0]  in_second_z,
  input  wire logic [TAG_W-1:0]              in_segment_tag,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [OUT_W-1:0]            out_first_sx,
  output logic signed [OUT_W-1:0]            out_first_sy,
  output logic signed [OUT_W-1:0]            out_second_sx,
  output logic signed [OUT_W-1:0]            out_second_sy,
  output logic [TAG_W-1:0]                   out_tag_out
);

  localparam logic [1:0] TRIG_SETTLE = 2'd3;

  logic [ROT_W-1:0]        rotation_r;
  logic [INCL_W-1:0]       incl_r;
  logic [OFS_W-1:0]        x_off_r;
  logic [OFS_W-1:0]        y_off_r;
  logic [1:0]              busy_r;
  logic [NSTG-1:0]         valid_r;
  logic [NSTG-1:0]         valid_nxt;
  logic [NSTG-1:0]         rdy;
  logic [NSTG-1:0]         adv;
  logic                    accept;
  srp_adv_t                adv_s;
  logic signed [SC_W-1:0]  sin_val;
  logic signed [SC_W-1:0]  cos_val;
  logic [TAG_W-1:0]        tag_r [0:NSTG-1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= '0;
      incl_r     <= INCL_W'(INCL_RESET);
      x_off_r    <= '0;
      y_off_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROTATION:    rotation_r <= cfg_wdata[ROT_W-1:0];
        CFG_INCLINATION: incl_r     <= cfg_wdata[INCL_W-1:0];
        CFG_X_OFFSET:    x_off_r    <= cfg_wdata[OFS_W-1:0];
        CFG_Y_OFFSET:    y_off_r    <= cfg_wdata[OFS_W-1:0];
        default:         ;
      endcase
    end
  end

  // Settle counter, loaded on every configuration write: the trig pipeline must settle after an angle change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= TRIG_SETTLE;
    end else if (cfg_we) begin
      busy_r <= TRIG_SETTLE;
    end else if (busy_r != '0) begin
      busy_r <= busy_r - 2'd1;
    end
  end

  // Per-stage ready chain, from the output back to the input
  always_comb begin
    rdy[NSTG-1] = !valid_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0] || (busy_r != '0) || cfg_we;
  assign accept   = in_valid && !in_stall;

  // Valid bits and load enables
  always_comb begin
    adv[0]       = accept;
    valid_nxt[0] = rdy[0] ? accept : valid_r[0];
    for (int k = 1; k < NSTG; k++) begin
      adv[k]       = rdy[k] && valid_r[k-1];
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign adv_s.st0 = adv[0];
  assign adv_s.st1 = adv[1];
  assign adv_s.st2 = adv[2];
  assign adv_s.st3 = adv[3];
  assign adv_s.st4 = adv[4];
  assign adv_s.st5 = adv[5];

  // Tag rides alongside the datapath
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tag_r[0] <= in_segment_tag;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  srp_trig u_trig (
    .clk      (clk),
    .rotation (rotation_r),
    .sin_val  (sin_val),
    .cos_val  (cos_val)
  );

  srp_point u_first (
    .clk     (clk),
    .adv     (adv_s),
    .sin_val (sin_val),
    .cos_val (cos_val),
    .incl    (incl_r),
    .x_off   (x_off_r),
    .y_off   (y_off_r),
    .in_x    (in_first_x),
    .in_y    (in_first_y),
    .in_z    (in_first_z),
    .out_sx  (out_first_sx),
    .out_sy  (out_first_sy)
  );

  srp_point u_second (
    .clk     (clk),
    .adv     (adv_s),
    .sin_val (sin_val),
    .cos_val (cos_val),
    .incl    (incl_r),
    .x_off   (x_off_r),
    .y_off   (y_off_r),
    .in_x    (in_second_x),
    .in_y    (in_second_y),
    .in_z    (in_second_z),
    .out_sx  (out_second_sx),
    .out_sy  (out_second_sy)
  );

  assign out_valid   = valid_r[NSTG-1];
  assign out_tag_out = tag_r[NSTG-1];

  // Checks
  `SRP_ASSERT_NOW(a_cfg_blocks_input, cfg_we, in_stall, "request accepted during config write")
  `SRP_ASSERT_NOW(a_settle_blocks_input, busy_r != 2'd0, in_stall, "request taken before trig settled")
  `SRP_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_r[0], "accepted request lost")
  `SRP_ASSERT_NEXT(a_stall_keeps_stage, valid_r[NSTG-1] && out_stall && valid_r[NSTG-2], valid_r[NSTG-2], "stage dropped under stall")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import srp_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int RANDOM_SETS     = 5;
  localparam int SETTLE_CYCLES   = 16;   // pipeline depth plus margin
  localparam int QUIET_LIMIT     = 1000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic [TAG_W-1:0]             tag;
  } segment_t;

  typedef struct {
    logic signed [OUT_W-1:0] first_sx;
    logic signed [OUT_W-1:0] first_sy;
    logic signed [OUT_W-1:0] second_sx;
    logic signed [OUT_W-1:0] second_sy;
    logic [TAG_W-1:0]        tag;
  } screen_t;

  typedef struct {
    segment_t seg;
    bit       fixed_want;
    screen_t  want;
  } dir_row_t;

  typedef struct {
    logic [CFG_W-1:0] rot;
    logic [CFG_W-1:0] incl;
    logic [CFG_W-1:0] xofs;
    logic [CFG_W-1:0] yofs;
  } reg_set_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // Directed segments. Rows with fixed results assume the reset registers:
  // no rotation, inclination one half, zero offsets, so
  // sx = trunc((x - y) / 2) and sy = trunc((x + y) / 2 - z).
  dir_row_t dir_rows [10] = '{
    '{'{0, 0, 0, 0, 0, 0, 16'h0000}, 1'b1, '{0, 0, 0, 0, 16'h0000}},
    '{'{100, 50, 10, -32768, -32768, -32768, 16'hFFFF}, 1'b1,
      '{25, 65, 0, 0, 16'hFFFF}},
    '{'{32767, -32767, 32767, -32768, 32766, 0, 16'h5A5A}, 1'b1,
      '{32767, -32767, -32767, -1, 16'h5A5A}},
    // a negative half rounds toward zero in both sx and sy
    '{'{-1, 0, 0, 32767, 32767, -32768, 16'h8001}, 1'b1,
      '{0, 0, 0, 65535, 16'h8001}},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 16'h0001}, 1'b0,
      '{0, 0, 0, 0, 0}},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, 16'h8000}, 1'b0,
      '{0, 0, 0, 0, 0}},
    '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0,
      '{0, 0, 0, 0, 0}},
    '{'{32767, -32768, -32768, -32768, 32767, 32767, 16'h7FFF}, 1'b0,
      '{0, 0, 0, 0, 0}},
    '{'{-1, -1, -1, -1, -1, -1, 16'h5555}, 1'b0, '{0, 0, 0, 0, 0}},
    '{'{1, -1, 1, -1, 1, -1, 16'h0002}, 1'b0, '{0, 0, 0, 0, 0}}
  };

  // Register settings: quadrant edges, angle wrap, inclination zero, one
  // and above one, offset extremes, spare bits set on the narrow registers
  reg_set_t fixed_sets [7] = '{
    '{900, 65536, 4095, 4095},
    '{1800, 0, 2048, 100},
    '{2700, 131071, 0, 4095},
    '{3599, 1, 4095, 0},
    '{17'h1FFFF, 98304, 17'h1F000, 17'h1EFFF},
    '{3600, 65537, 1234, 3000},
    '{450, 32768, 17'h0AAAA, 17'h15555}
  };

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] in_first_x;
  logic signed [COORD_BITS-1:0] in_first_y;
  logic signed [COORD_BITS-1:0] in_first_z;
  logic signed [COORD_BITS-1:0] in_second_x;
  logic signed [COORD_BITS-1:0] in_second_y;
  logic signed [COORD_BITS-1:0] in_second_z;
  logic [TAG_W-1:0]             in_segment_tag;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [OUT_W-1:0]      out_first_sx;
  logic signed [OUT_W-1:0]      out_first_sy;
  logic signed [OUT_W-1:0]      out_second_sx;
  logic signed [OUT_W-1:0]      out_second_sy;
  logic [TAG_W-1:0]             out_tag_out;

  // Shadow registers and the trig values they select
  logic [ROT_W-1:0]  rot_r;
  logic [INCL_W-1:0] incl_r;
  logic [OFS_W-1:0]  xofs_r;
  logic [OFS_W-1:0]  yofs_r;
  longint            sin_v;
  longint            cos_v;

  screen_t     screen_q [$];
  int          bad_count   = 0;
  int          quiet_count = 0;
  int          burst_left  = 0;
  int          stall_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  segment_rotate_project DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_first_z     (in_first_z),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_second_z    (in_second_z),
    .in_segment_tag (in_segment_tag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first_sx   (out_first_sx),
    .out_first_sy   (out_first_sy),
    .out_second_sx  (out_second_sx),
    .out_second_sy  (out_second_sy),
    .out_tag_out    (out_tag_out)
  );

  always #1 clk = ~clk;

  // sin over the first quadrant, t in tenths of a degree: Taylor series in
  // Q30, then rounded to the trig fraction width
  function automatic longint quarter_sine(int unsigned t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    int unsigned     k;
    x    = (64'(t) * PI_Q30 + 64'(HALF_TENTHS / 2)) / 64'(HALF_TENTHS);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc  = longint'(x);
    for (k = 1; k <= 11; k++) begin
      term = ((term * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return (acc + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
  endfunction

  // Fold the angle into a quadrant and pick signed sin / cos
  function automatic void update_trig();
    int unsigned t;
    int unsigned q;
    int unsigned r;
    longint      a;
    longint      b;
    t = rot_r % FULL_TENTHS;
    q = t / QUARTER_TENTHS;
    r = t % QUARTER_TENTHS;
    a = quarter_sine(r);
    b = quarter_sine(QUARTER_TENTHS - r);
    case (q)
      0: begin sin_v = a;  cos_v = b;  end
      1: begin sin_v = b;  cos_v = -a; end
      2: begin sin_v = -a; cos_v = -b; end
      default: begin sin_v = -b; cos_v = a; end
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_screen(longint v);
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end
    if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return OUT_W'(v);
  endfunction

  // Rotate one endpoint, project it, truncate toward zero and clip
  function automatic void project_point(input longint x, input longint y,
                                        input longint z,
                                        output logic signed [OUT_W-1:0] sx,
                                        output logic signed [OUT_W-1:0] sy);
    longint rx;
    longint ry;
    longint incl;
    longint unit;
    rx   = x * cos_v - y * sin_v;
    ry   = x * sin_v + y * cos_v;
    incl = longint'(incl_r);
    unit = longint'(1) <<< (TRIG_FRAC_BITS + INCL_FRAC);
    sx = clip_screen((incl * (rx - ry) + longint'(xofs_r) * unit) / unit);
    sy = clip_screen(((longint'(INCL_ONE) - incl) * (rx + ry) - z * unit
                      + longint'(yofs_r) * unit) / unit);
  endfunction

  function automatic screen_t project_segment(segment_t seg);
    screen_t res;
    project_point(seg.first_x, seg.first_y, seg.first_z, res.first_sx, res.first_sy);
    project_point(seg.second_x, seg.second_y, seg.second_z,
                  res.second_sx, res.second_sy);
    res.tag = seg.tag;
    return res;
  endfunction

  // Coordinates lean on the extremes now and then
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(COORD_BITS - 1){1'b1}}};
      1: return {1'b1, {(COORD_BITS - 1){1'b0}}};
      2: return '0;
      3: return '1;
      4: return COORD_BITS'(int'($urandom_range(0, 255)) - 128);
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t seg;
    seg.first_x  = pick_coord();
    seg.first_y  = pick_coord();
    seg.first_z  = pick_coord();
    seg.second_x = pick_coord();
    seg.second_y = pick_coord();
    seg.second_z = pick_coord();
    seg.tag      = TAG_W'($urandom());
    return seg;
  endfunction

  // One register write; cfg_we is lowered by the caller after the last one
  task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ROTATION:    rot_r  = data[ROT_W-1:0];
      CFG_INCLINATION: incl_r = data[INCL_W-1:0];
      CFG_X_OFFSET:    xofs_r = data[OFS_W-1:0];
      CFG_Y_OFFSET:    yofs_r = data[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(reg_set_t set);
    put_reg(CFG_ROTATION, set.rot);
    put_reg(CFG_INCLINATION, set.incl);
    put_reg(CFG_X_OFFSET, set.xofs);
    put_reg(CFG_Y_OFFSET, set.yofs);
    cfg_we <= 1'b0;
    update_trig();
  endtask

  // Present one request and hold it until accepted
  task automatic send_segment(segment_t seg, bit fixed_want, screen_t want);
    in_valid       <= 1'b1;
    in_first_x     <= seg.first_x;
    in_first_y     <= seg.first_y;
    in_first_z     <= seg.first_z;
    in_second_x    <= seg.second_x;
    in_second_y    <= seg.second_y;
    in_second_z    <= seg.second_z;
    in_segment_tag <= seg.tag;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    screen_q.push_back(fixed_want ? want : project_segment(seg));
  endtask

  // Sender bursts: keep valid up while the burst lasts, else idle a while
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Stop sending, let every result come back and the pipeline go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (screen_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    screen_t none;
    int      i;
    none = '{0, 0, 0, 0, 0};
    for (i = 0; i < ITEMS_PER_PHASE; i++) begin
      send_segment(random_segment(), 1'b0, none);
      pace();
    end
    drain();
  endtask

  task automatic note_field(string name, longint want, longint got);
    if (want != got) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS) begin
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  // Stimulus
  initial begin
    reg_set_t set;
    int       i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_first_x     = '0;
    in_first_y     = '0;
    in_first_z     = '0;
    in_second_x    = '0;
    in_second_y    = '0;
    in_second_z    = '0;
    in_segment_tag = '0;
    rot_r          = '0;
    incl_r         = INCL_W'(INCL_RESET);
    xofs_r         = '0;
    yofs_r         = '0;
    update_trig();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests on the reset registers
    for (i = 0; i < $size(dir_rows); i++) begin
      send_segment(dir_rows[i].seg, dir_rows[i].fixed_want, dir_rows[i].want);
      pace();
    end
    random_phase();

    for (i = 0; i < $size(fixed_sets); i++) begin
      program_regs(fixed_sets[i]);
      random_phase();
    end

    for (i = 0; i < RANDOM_SETS; i++) begin
      set.rot  = CFG_W'($urandom());
      set.incl = CFG_W'($urandom());
      set.xofs = CFG_W'($urandom());
      set.yofs = CFG_W'($urandom());
      program_regs(set);
      random_phase();
    end

    if (bad_count == 0 && screen_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Result checking, receiver stalls and the watchdog
  always @(posedge clk) begin
    screen_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (screen_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS) begin
          $display("mismatch: result with tag %h but none expected", out_tag_out);
        end
      end else begin
        want = screen_q.pop_front();
        note_field("first_sx", want.first_sx, out_first_sx);
        note_field("first_sy", want.first_sy, out_first_sy);
        note_field("second_sx", want.second_sx, out_second_sx);
        note_field("second_sy", want.second_sy, out_second_sy);
        note_field("tag_out", want.tag, out_tag_out);
      end
    end

    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end

    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(30, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default:      out_stall <= 1'b0;
    endcase
  end

endmodule
